// File: rtl/core/skf_pkg.sv
package skf_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DATA_W    = 32;
  localparam int GAIN_W    = FRAC_BITS + 1;
  localparam int DEN_W     = DATA_W + 1;
  localparam int REM_W     = DATA_W + 2;
  localparam int ACC_W     = GAIN_W + DEN_W + 1;
  localparam int CNT_W     = $clog2(GAIN_W);
  localparam int PC_W      = 4;
  localparam int ROM_DEPTH = 1 << PC_W;
  localparam int ADDR_W    = 3;

  localparam logic [DATA_W-1:0] COV_ONE  = DATA_W'(1) << FRAC_BITS;
  localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1) << FRAC_BITS;
  localparam logic [CNT_W-1:0]  ITER_LAST = CNT_W'(GAIN_W - 1);

  localparam logic REG_PROCESS_NOISE     = 1'b0;
  localparam logic REG_MEASUREMENT_NOISE = 1'b1;

  typedef logic [PC_W-1:0] pc_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_IDLE,
    OP_PRED,
    OP_DEN,
    OP_DIV,
    OP_MSET,
    OP_MUL,
    OP_XUPD,
    OP_PUPD,
    OP_EMIT
  } op_t;

  typedef enum logic [2:0] {
    CND_NONE,
    CND_ALWAYS,
    CND_NO_INPUT,
    CND_DEN_ZERO,
    CND_CNT_NZ,
    CND_OUT_BUSY
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    pc_t   target;
    logic  cnt_ld;
    logic  cnt_dec;
  } uword_t;

  typedef struct packed {
    logic in_valid;
    logic out_busy;
    logic den_zero;
  } seq_stat_t;

  localparam pc_t PC_IDLE  = 4'd0;
  localparam pc_t PC_CHK   = 4'd3;
  localparam pc_t PC_DIV   = 4'd4;
  localparam pc_t PC_MSET  = 4'd5;
  localparam pc_t PC_MUL1  = 4'd6;
  localparam pc_t PC_MUL2  = 4'd8;
  localparam pc_t PC_EMIT  = 4'd10;

endpackage

// File: rtl/core/skf_ucode_rom.sv
module skf_ucode_rom
  import skf_pkg::*;
(
  input  pc_t    pc,
  output uword_t uword
);

  always_comb begin
    unique case (pc)
      4'd0:    uword = '{OP_IDLE, CND_NO_INPUT, PC_IDLE, 1'b0, 1'b0};
      4'd1:    uword = '{OP_PRED, CND_NONE,     PC_IDLE, 1'b0, 1'b0};
      4'd2:    uword = '{OP_DEN,  CND_NONE,     PC_IDLE, 1'b1, 1'b0};
      4'd3:    uword = '{OP_NOP,  CND_DEN_ZERO, PC_MSET, 1'b0, 1'b0};
      4'd4:    uword = '{OP_DIV,  CND_CNT_NZ,   PC_DIV,  1'b0, 1'b1};
      4'd5:    uword = '{OP_MSET, CND_NONE,     PC_IDLE, 1'b1, 1'b0};
      4'd6:    uword = '{OP_MUL,  CND_CNT_NZ,   PC_MUL1, 1'b0, 1'b1};
      4'd7:    uword = '{OP_XUPD, CND_NONE,     PC_IDLE, 1'b1, 1'b0};
      4'd8:    uword = '{OP_MUL,  CND_CNT_NZ,   PC_MUL2, 1'b0, 1'b1};
      4'd9:    uword = '{OP_PUPD, CND_NONE,     PC_IDLE, 1'b0, 1'b0};
      4'd10:   uword = '{OP_EMIT, CND_OUT_BUSY, PC_EMIT, 1'b0, 1'b0};
      default: uword = '{OP_NOP,  CND_ALWAYS,   PC_IDLE, 1'b0, 1'b0};
    endcase
  end

endmodule

// File: rtl/core/skf_sequencer.sv
module skf_sequencer
  import skf_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  seq_stat_t stat,
  output op_t       op
);

  pc_t             pc_r, pc_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  uword_t          uword;
  logic            take;

  skf_ucode_rom u_rom (
    .pc    (pc_r),
    .uword (uword)
  );

  assign op = uword.op;

  always_comb begin
    unique case (uword.cond)
      CND_NONE:     take = 1'b0;
      CND_ALWAYS:   take = 1'b1;
      CND_NO_INPUT: take = !stat.in_valid;
      CND_DEN_ZERO: take = stat.den_zero;
      CND_CNT_NZ:   take = (cnt_r != '0);
      CND_OUT_BUSY: take = stat.out_busy;
      default:      take = 1'b1;
    endcase
    pc_nxt = take ? uword.target : pc_r + pc_t'(1);
    if (uword.cnt_ld) begin
      cnt_nxt = ITER_LAST;
    end else if (uword.cnt_dec) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end else begin
      cnt_nxt = cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r  <= PC_IDLE;
      cnt_r <= '0;
    end else begin
      pc_r  <= pc_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  a_loop_counts_down: assert property (@(posedge clk) disable iff (!rst_n)
    (uword.cnt_dec && cnt_r != '0) |=> (cnt_r == $past(cnt_r) - CNT_W'(1)))
    else $error("loop counter did not advance");

  a_idle_leaves_on_input: assert property (@(posedge clk) disable iff (!rst_n)
    (pc_r == PC_IDLE && stat.in_valid) |=> (pc_r == PC_IDLE + pc_t'(1)))
    else $error("sequencer did not start on input");

endmodule

// File: rtl/core/skf_datapath.sv
module skf_datapath
  import skf_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  op_t               op,
  input  logic              load_z,
  input  logic [DATA_W-1:0] meas,
  input  logic [DATA_W-1:0] q_noise,
  input  logic [DATA_W-1:0] r_noise,
  output logic [DATA_W-1:0] x_est,
  output logic              den_zero
);

  logic [DATA_W-1:0] x_r, x_nxt;
  logic [DATA_W-1:0] p_r, p_nxt;
  logic [DATA_W-1:0] z_r;
  logic [DATA_W-1:0] ppre_r, ppre_nxt;
  logic [DEN_W-1:0]  den_r, den_nxt;
  logic [REM_W-1:0]  rem_r, rem_nxt;
  logic [GAIN_W-1:0] gain_r, gain_nxt;
  logic [GAIN_W-1:0] mul_r, mul_nxt;
  logic [ACC_W-1:0]  mcand_r, mcand_nxt;
  logic [ACC_W-1:0]  acc_r, acc_nxt;
  logic [DEN_W-1:0]  cov_sum;
  logic [DEN_W-1:0]  diff;
  logic              rem_ge;
  logic [REM_W-1:0]  rem_sub;

  assign cov_sum  = {1'b0, p_r} + {1'b0, q_noise};
  assign diff     = {z_r[DATA_W-1], z_r} - {x_r[DATA_W-1], x_r};
  assign rem_ge   = rem_r >= {1'b0, den_r};
  assign rem_sub  = rem_ge ? rem_r - {1'b0, den_r} : rem_r;
  assign den_zero = (den_r == '0);
  assign x_est    = x_r;

  always_comb begin
    x_nxt     = x_r;
    p_nxt     = p_r;
    ppre_nxt  = ppre_r;
    den_nxt   = den_r;
    rem_nxt   = rem_r;
    gain_nxt  = gain_r;
    mul_nxt   = mul_r;
    mcand_nxt = mcand_r;
    acc_nxt   = acc_r;
    unique case (op)
      OP_PRED: begin
        ppre_nxt = cov_sum[DATA_W] ? '1 : cov_sum[DATA_W-1:0];
      end
      OP_DEN: begin
        den_nxt  = {1'b0, ppre_r} + {1'b0, r_noise};
        rem_nxt  = {2'b00, ppre_r};
        gain_nxt = '0;
      end
      OP_DIV: begin
        rem_nxt  = {rem_sub[REM_W-2:0], 1'b0};
        gain_nxt = {gain_r[GAIN_W-2:0], rem_ge};
      end
      OP_MSET: begin
        mcand_nxt = {{(ACC_W-DEN_W){diff[DEN_W-1]}}, diff};
        mul_nxt   = gain_r;
        acc_nxt   = '0;
      end
      OP_MUL: begin
        acc_nxt = {acc_r[ACC_W-2:0], 1'b0} + (mul_r[GAIN_W-1] ? mcand_r : '0);
        mul_nxt = {mul_r[GAIN_W-2:0], 1'b0};
      end
      OP_XUPD: begin
        x_nxt     = x_r + acc_r[FRAC_BITS+DATA_W-1:FRAC_BITS];
        mcand_nxt = {{(ACC_W-DATA_W){1'b0}}, ppre_r};
        mul_nxt   = GAIN_ONE - gain_r;
        acc_nxt   = '0;
      end
      OP_PUPD: begin
        p_nxt = acc_r[FRAC_BITS+DATA_W-1:FRAC_BITS];
      end
      OP_NOP, OP_IDLE, OP_EMIT: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r <= '0;
      p_r <= COV_ONE;
    end else begin
      x_r <= x_nxt;
      p_r <= p_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_z) begin
      z_r <= meas;
    end
    ppre_r  <= ppre_nxt;
    den_r   <= den_nxt;
    rem_r   <= rem_nxt;
    gain_r  <= gain_nxt;
    mul_r   <= mul_nxt;
    mcand_r <= mcand_nxt;
    acc_r   <= acc_nxt;
  end

  a_cov_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    (op == OP_PUPD) |=> (p_r <= $past(ppre_r)))
    else $error("covariance grew in update");

  a_gain_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (op == OP_MSET && !den_zero) |-> (gain_r <= GAIN_ONE))
    else $error("gain above one");

endmodule

// File: rtl/core/scalar_kalman_filter.sv
// channel  | handshake                    | payload
// in       | in_valid / in_stall          | in_measurement  (s32, Q16.16)
// out      | out_valid / out_stall        | out_estimate    (s32, Q16.16)
// cfg      | psel penable pwrite pready   | paddr pwdata prdata (Q, R at 0x0, 0x4)
//
// Each item runs the 17-step restoring divide (skipped when p+Q+R is zero) and two
// 17-step shift-add multiplies before the result is loaded.
// After the load the sequencer steps back to idle, and only then accepts the next item.
// A stalled result holds the sequencer at its last step; the next item waits.
// Reset: estimate 0, covariance 1.0, Q and R 1.0.
module scalar_kalman_filter
  import skf_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [DATA_W-1:0] in_measurement,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [DATA_W-1:0] out_estimate,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  logic [DATA_W-1:0] q_r;
  logic [DATA_W-1:0] r_r;
  logic [DATA_W-1:0] out_r;
  logic              out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0] x_est;
  logic              den_zero;
  logic              accept;
  logic              emit;
  logic              out_busy;
  logic              cfg_wr;
  op_t               op;
  seq_stat_t         stat;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite;
  assign prdata   = (paddr[2] == REG_MEASUREMENT_NOISE) ? r_r : q_r;

  assign in_stall = (op != OP_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_busy = out_valid_r && out_stall;
  assign emit     = (op == OP_EMIT) && !out_busy;

  assign stat = '{in_valid: in_valid, out_busy: out_busy, den_zero: den_zero};

  skf_sequencer u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .op    (op)
  );

  skf_datapath u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .op       (op),
    .load_z   (accept),
    .meas     (in_measurement),
    .q_noise  (q_r),
    .r_noise  (r_r),
    .x_est    (x_est),
    .den_zero (den_zero)
  );

  always_comb begin
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r         <= COV_ONE;
      r_r         <= COV_ONE;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cfg_wr && paddr[2] == REG_PROCESS_NOISE) begin
        q_r <= pwdata;
      end
      if (cfg_wr && paddr[2] == REG_MEASUREMENT_NOISE) begin
        r_r <= pwdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_r <= x_est;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_estimate = out_r;

  a_one_item_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> in_stall)
    else $error("item accepted while busy");

  a_emit_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> (out_valid && out_estimate == $past(x_est)))
    else $error("result not presented");

endmodule

// File: sim/tb_scalar_kalman_filter.sv
module tb_scalar_kalman_filter;
  import skf_pkg::*;

  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 100;
  localparam int ITEMS_PER_SETTING = 100;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [DATA_W-1:0] in_measurement = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [DATA_W-1:0] out_estimate;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  // filter state and noise settings as the block should hold them
  logic [DATA_W-1:0] model_estimate = '0;
  logic [DATA_W-1:0] model_covariance = COV_ONE;
  logic [DATA_W-1:0] model_process_noise = COV_ONE;
  logic [DATA_W-1:0] model_measurement_noise = COV_ONE;

  logic [DATA_W-1:0] pending_estimates[$];
  logic [DATA_W-1:0] oldest_estimate;
  int                failures = 0;
  int                quiet_cycles = 0;
  int                sender_gap_pct = 0;
  int                receiver_stall_pct = 0;
  logic [DATA_W-1:0] signal_level = '0;

  scalar_kalman_filter dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_measurement(in_measurement),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_estimate(out_estimate),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic logic [DATA_W-1:0] kalman_update(input logic [DATA_W-1:0] z);
    logic [63:0]    p_pre;
    logic [63:0]    denom;
    logic [63:0]    gain;
    logic [63:0]    p_next;
    longint signed  diff;
    longint signed  delta;
    longint signed  x_next;
    p_pre = {32'd0, model_covariance} + {32'd0, model_process_noise};
    if (p_pre > 64'hFFFF_FFFF) begin
      p_pre = 64'hFFFF_FFFF;
    end
    denom = p_pre + {32'd0, model_measurement_noise};
    gain = (denom == 64'd0) ? 64'd0 : ((p_pre << FRAC_BITS) / denom);
    diff = longint'(signed'(z)) - longint'(signed'(model_estimate));
    delta = (longint'(gain) * diff) >>> FRAC_BITS;
    x_next = longint'(signed'(model_estimate)) + delta;
    p_next = (((64'd1 << FRAC_BITS) - gain) * p_pre) >> FRAC_BITS;
    model_estimate = x_next[DATA_W-1:0];
    model_covariance = p_next[DATA_W-1:0];
    return model_estimate;
  endfunction

  always @(negedge clk) begin
    out_stall <= rst_n && ($urandom_range(99) < receiver_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_estimates.size() == 0) begin
        $error("estimate: expected none, got %h", out_estimate);
        failures++;
      end else begin
        oldest_estimate = pending_estimates.pop_front();
        if (out_estimate !== oldest_estimate) begin
          $error("estimate: expected %h, got %h", oldest_estimate, out_estimate);
          failures++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("scalar_kalman_filter: mismatch");
      $finish;
    end
  end

  task automatic send_measurement(input logic [DATA_W-1:0] z);
    @(negedge clk);
    while ($urandom_range(99) < sender_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_measurement <= z;
    do @(posedge clk); while (in_stall);
    pending_estimates.push_back(kalman_update(z));
  endtask

  task automatic drain_filter();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_estimates.size() != 0) @(posedge clk);
  endtask

  task automatic write_noise(input logic reg_index, input logic [DATA_W-1:0] value);
    drain_filter();
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'(reg_index) << 2;
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (reg_index == REG_PROCESS_NOISE) begin
      model_process_noise = value;
    end else begin
      model_measurement_noise = value;
    end
    @(negedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== value) begin
      $error("prdata: expected %h, got %h", value, prdata);
      failures++;
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic test_reset_defaults();
    send_measurement(32'h0001_0000);
    send_measurement(32'hFFFF_0000);
    send_measurement(32'h0000_0000);
  endtask

  task automatic test_measurement_extremes();
    send_measurement(32'h7FFF_FFFF);
    send_measurement(32'h8000_0000);
    send_measurement(32'h7FFF_FFFF);
    send_measurement(32'h8000_0000);
    send_measurement(32'hFFFF_FFFF);
    send_measurement(32'h0000_0001);
  endtask

  // gain of exactly one: estimate snaps to the measurement, covariance drops to 0
  task automatic test_zero_measurement_noise();
    write_noise(REG_MEASUREMENT_NOISE, 32'd0);
    send_measurement(32'h1234_5678);
    send_measurement(32'h8000_0000);
  endtask

  // covariance and both noises zero: gain is 0, estimate must hold
  task automatic test_zero_denominator();
    write_noise(REG_PROCESS_NOISE, 32'd0);
    send_measurement(32'h7FFF_FFFF);
    send_measurement(32'h5555_5555);
  endtask

  task automatic test_covariance_saturation();
    write_noise(REG_PROCESS_NOISE, 32'hFFFF_FFFF);
    write_noise(REG_MEASUREMENT_NOISE, 32'hFFFF_FFFF);
    send_measurement(32'h4000_0000);
    send_measurement(32'hC000_0000);
    send_measurement(32'h7FFF_FFFF);
    write_noise(REG_MEASUREMENT_NOISE, 32'd1);
    send_measurement(32'h8000_0000);
    send_measurement(32'h2AAA_AAAA);
  endtask

  task automatic pick_noise_setting();
    logic [DATA_W-1:0] q_val;
    logic [DATA_W-1:0] r_val;
    case ($urandom_range(4))
      0: begin
        q_val = COV_ONE;
        r_val = $urandom_range(32'h0000_8000, 32'h0002_0000);
      end
      1: begin
        q_val = $urandom_range(0, 32'h0001_0000);
        r_val = $urandom_range(0, 32'h0010_0000);
      end
      2: begin
        q_val = $urandom;
        r_val = $urandom;
      end
      3: begin
        q_val = $urandom_range(1) ? 32'hFFFF_FFFF : 32'd0;
        r_val = $urandom_range(1) ? 32'hFFFF_FFFF : 32'd0;
      end
      default: begin
        q_val = $urandom_range(0, 255);
        r_val = $urandom;
      end
    endcase
    write_noise(REG_PROCESS_NOISE, q_val);
    write_noise(REG_MEASUREMENT_NOISE, r_val);
  endtask

  // mostly a noisy level with occasional steps, plus wild, extreme and near-zero samples
  task automatic send_random_measurement();
    logic [DATA_W-1:0] z;
    int                kind;
    int                amp;
    kind = $urandom_range(99);
    if (kind < 65) begin
      amp = $urandom_range(4, 20);
      z = signal_level + $urandom_range(0, 1 << amp) - (1 << (amp - 1));
    end else if (kind < 75) begin
      signal_level = $urandom;
      z = signal_level;
    end else if (kind < 88) begin
      z = $urandom;
    end else if (kind < 94) begin
      case ($urandom_range(3))
        0: z = 32'h8000_0000;
        1: z = 32'h7FFF_FFFF;
        2: z = 32'h0000_0000;
        default: z = 32'hFFFF_FFFF;
      endcase
    end else begin
      z = $urandom_range(0, 255) - 128;
    end
    send_measurement(z);
  endtask

  task automatic test_random_traffic(input int gap_pct, input int stall_pct);
    sender_gap_pct = gap_pct;
    receiver_stall_pct = stall_pct;
    repeat (4) begin
      pick_noise_setting();
      signal_level = $urandom;
      repeat (ITEMS_PER_SETTING) send_random_measurement();
    end
  endtask

  initial begin
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    sender_gap_pct = 7;
    receiver_stall_pct = 61;
    test_reset_defaults();
    test_measurement_extremes();
    test_zero_measurement_noise();
    test_zero_denominator();
    test_covariance_saturation();
    test_random_traffic(7, 61);
    test_random_traffic(61, 7);
    test_random_traffic(0, 0);
    drain_filter();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("scalar_kalman_filter: match");
    end else begin
      $display("scalar_kalman_filter: mismatch");
    end
    $finish;
  end

endmodule
